// ===== hdl/lprp_pkg.sv =====
// ----------------------------------------------------------------------------
// lprp_pkg: shared types and constants of the length-prefixed request parser
// Field widths, limits, phase, role and error codes, and the state and result
// structures passed between the step logic and the top level.
// ----------------------------------------------------------------------------
package lprp_pkg;

  // Field widths.
  localparam int BYTE_W = 8;
  localparam int BODY_W = 13;  // body length and byte counters, up to 4096
  localparam int ARGC_W = 11;  // argument count, up to 1024
  localparam int ARGI_W = 10;  // argument index, wraps modulo 1024
  localparam int ROLE_W = 3;
  localparam int ERR_W  = 3;
  localparam int HDR_W  = 32;  // one little-endian header word
  localparam int HOLD_W = 24;  // header bytes held until the word is complete
  localparam int CFG_W  = 13;  // widest configuration register
  localparam int CIDX_W = 1;   // configuration register index

  // Hard limits that the configuration registers are clamped to.
  localparam logic [BODY_W-1:0] BODY_LIMIT = BODY_W'(4096);
  localparam logic [ARGC_W-1:0] ARG_LIMIT  = ARGC_W'(1024);
  localparam logic [HDR_W-1:0]  MIN_BODY   = HDR_W'(4);
  localparam logic [BODY_W-1:0] HDR_BYTES  = BODY_W'(4);

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_MAX_BODY_LEN  = 1'd0;
  localparam logic [CIDX_W-1:0] CFG_MAX_ARG_COUNT = 1'd1;

  // Parse phases.
  localparam logic [1:0] PH_LEN   = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_ALEN  = 2'd2;
  localparam logic [1:0] PH_DATA  = 2'd3;

  // Byte roles.
  localparam logic [ROLE_W-1:0] ROLE_LEN   = 3'd0;
  localparam logic [ROLE_W-1:0] ROLE_COUNT = 3'd1;
  localparam logic [ROLE_W-1:0] ROLE_ALEN  = 3'd2;
  localparam logic [ROLE_W-1:0] ROLE_DATA  = 3'd3;
  localparam logic [ROLE_W-1:0] ROLE_DROP  = 3'd4;

  // Error codes.
  localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
  localparam logic [ERR_W-1:0] ERR_LEN_BIG   = 3'd1;
  localparam logic [ERR_W-1:0] ERR_LEN_SMALL = 3'd2;
  localparam logic [ERR_W-1:0] ERR_ARGS      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_HDR_OVR   = 3'd4;
  localparam logic [ERR_W-1:0] ERR_DATA_OVR  = 3'd5;
  localparam logic [ERR_W-1:0] ERR_TRAILING  = 3'd6;

  typedef struct packed {
    logic [1:0]        phase;
    logic [1:0]        fcnt;
    logic [HOLD_W-1:0] hdr;
    logic [BODY_W-1:0] body_rem;
    logic [ARGC_W-1:0] args_rem;
    logic [ARGI_W-1:0] arg_idx;
    logic [BODY_W-1:0] arg_bytes_rem;
    logic              closed;
  } parse_state_t;

  typedef struct packed {
    logic [BYTE_W-1:0] byte_out;
    logic [ROLE_W-1:0] byte_role;
    logic [ARGI_W-1:0] arg_number;
    logic              arg_done;
    logic              request_done;
    logic [ERR_W-1:0]  error_code;
  } parse_result_t;

endpackage

// ===== hdl/lprp_in_if.sv =====
// ----------------------------------------------------------------------------
// lprp_in_if: request byte channel
// Valid/ready channel carrying one stream byte per beat.
// ----------------------------------------------------------------------------
interface lprp_in_if;
  logic                          valid;
  logic                          ready;
  logic [lprp_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/lprp_out_if.sv =====
// ----------------------------------------------------------------------------
// lprp_out_if: tagged byte channel
// Valid/ready channel carrying one tagged byte per beat.
// ----------------------------------------------------------------------------
interface lprp_out_if;
  logic                          valid;
  logic                          ready;
  logic [lprp_pkg::BYTE_W-1:0]   byte_out;
  logic [lprp_pkg::ROLE_W-1:0]   byte_role;
  logic [lprp_pkg::ARGI_W-1:0]   arg_number;
  logic                          arg_done;
  logic                          request_done;
  logic [lprp_pkg::ERR_W-1:0]    error_code;

  modport source (output valid, output byte_out, output byte_role, output arg_number,
                  output arg_done, output request_done, output error_code, input ready);
  modport sink   (input valid, input byte_out, input byte_role, input arg_number,
                  input arg_done, input request_done, input error_code, output ready);
endinterface

// ===== hdl/lprp_step.sv =====
// ----------------------------------------------------------------------------
// lprp_step: parser step logic
// Classifies one byte against the current parse state and computes the next
// state together with the tagged result.
// ----------------------------------------------------------------------------
module lprp_step (
  input  lprp_pkg::parse_state_t           st_i,
  input  logic [lprp_pkg::BYTE_W-1:0]      byte_i,
  input  logic [lprp_pkg::BODY_W-1:0]      body_lim_i,
  input  logic [lprp_pkg::ARGC_W-1:0]      arg_lim_i,
  output lprp_pkg::parse_state_t           st_o,
  output lprp_pkg::parse_result_t          res_o
);

  logic [lprp_pkg::HDR_W-1:0]  word;
  logic                        full;
  logic                        do_finish;
  logic                        do_advance;
  logic [lprp_pkg::ERR_W-1:0]  err;
  lprp_pkg::parse_state_t      ns;
  lprp_pkg::parse_result_t     res;

  // The header word: the newest byte lands in the top byte (little endian).
  assign word = {byte_i, st_i.hdr};
  assign full = (st_i.fcnt == 2'd3);

  always_comb begin
    ns         = st_i;
    res        = '0;
    err        = lprp_pkg::ERR_NONE;
    do_finish  = 1'b0;
    do_advance = 1'b0;
    res.byte_out = byte_i;

    if (st_i.closed) begin
      res.byte_role = lprp_pkg::ROLE_DROP;
    end else begin
      res.byte_role = {1'b0, st_i.phase};
      if (st_i.phase == lprp_pkg::PH_ALEN || st_i.phase == lprp_pkg::PH_DATA) begin
        res.arg_number = st_i.arg_idx;
      end
      if (st_i.phase != lprp_pkg::PH_LEN && st_i.body_rem != '0) begin
        ns.body_rem = st_i.body_rem - 1'b1;
      end
      if (st_i.phase != lprp_pkg::PH_DATA) begin
        ns.hdr  = word[lprp_pkg::HDR_W-1:lprp_pkg::BYTE_W];
        ns.fcnt = st_i.fcnt + 2'd1;
      end

      case (st_i.phase)
        lprp_pkg::PH_LEN: begin
          if (full) begin
            if (word > {{(lprp_pkg::HDR_W-lprp_pkg::BODY_W){1'b0}}, body_lim_i}) begin
              err = lprp_pkg::ERR_LEN_BIG;
            end else if (word < lprp_pkg::MIN_BODY) begin
              err = lprp_pkg::ERR_LEN_SMALL;
            end else begin
              ns.body_rem = word[lprp_pkg::BODY_W-1:0];
              ns.phase    = lprp_pkg::PH_COUNT;
            end
          end
        end
        lprp_pkg::PH_COUNT: begin
          if (full) begin
            if (word > {{(lprp_pkg::HDR_W-lprp_pkg::ARGC_W){1'b0}}, arg_lim_i}) begin
              err = lprp_pkg::ERR_ARGS;
            end else begin
              ns.args_rem = word[lprp_pkg::ARGC_W-1:0];
              ns.arg_idx  = '0;
              do_advance  = 1'b1;
            end
          end
        end
        lprp_pkg::PH_ALEN: begin
          if (full) begin
            if (word > {{(lprp_pkg::HDR_W-lprp_pkg::BODY_W){1'b0}}, ns.body_rem}) begin
              err = lprp_pkg::ERR_DATA_OVR;
            end else if (word == '0) begin
              do_finish = 1'b1;
            end else begin
              ns.arg_bytes_rem = word[lprp_pkg::BODY_W-1:0];
              ns.phase         = lprp_pkg::PH_DATA;
            end
          end
        end
        default: begin
          if (st_i.arg_bytes_rem != '0) begin
            ns.arg_bytes_rem = st_i.arg_bytes_rem - 1'b1;
          end
          if (ns.arg_bytes_rem == '0) begin
            do_finish = 1'b1;
          end
        end
      endcase

      // End of an argument: count it off and move on to the next item.
      if (do_finish) begin
        res.arg_done = 1'b1;
        if (ns.args_rem != '0) begin
          ns.args_rem = ns.args_rem - 1'b1;
        end
        ns.arg_idx = ns.arg_idx + 1'b1;
        do_advance = 1'b1;
      end

      // Decide whether another argument header follows or the request ends.
      if (do_advance) begin
        if (ns.args_rem != '0) begin
          if (ns.body_rem < lprp_pkg::HDR_BYTES) begin
            err = lprp_pkg::ERR_HDR_OVR;
          end else begin
            ns.phase = lprp_pkg::PH_ALEN;
          end
        end else if (ns.body_rem != '0) begin
          err = lprp_pkg::ERR_TRAILING;
        end else begin
          res.request_done = 1'b1;
          ns.phase         = lprp_pkg::PH_LEN;
          ns.arg_idx       = '0;
        end
      end

      if (err != lprp_pkg::ERR_NONE) begin
        ns.closed        = 1'b1;
        res.request_done = 1'b0;
      end
      res.error_code = err;
    end
  end

  assign st_o  = ns;
  assign res_o = res;

endmodule

// ===== hdl/length_prefixed_request_parser_core.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_request_parser_core: length-prefixed request parser
// Tags each byte of a request stream with its role, argument index and
// completion marks, and flags framing errors on the byte that proves them.
//
// Usage:
//   Request bytes enter on in_ch, one byte per beat. Every byte leaves on
//   out_ch as one tagged beat, in order: the byte itself, its role, the
//   argument index, argument and request completion marks and an error code.
//   The two limits are written on the cfg_ port (index 0: largest body
//   length, index 1: largest argument count) while no byte is in flight.
//   An accepted input beat passes through the input register, which feeds
//   the step logic, and from there into the output register. One byte is
//   taken every cycle while out_ch.ready stays high.
//   When the receiver stalls, the output register holds its beat and the
//   input register holds one more byte; input ready drops only when both
//   are full and out_ch.ready is low. Synchronous reset clears the parse
//   state, empties both registers and restores both limits to their maximum.
//   After any error the parser stays closed and every later byte comes out
//   with the dropped role until reset.
// ----------------------------------------------------------------------------
module length_prefixed_request_parser_core (
  input  logic                              clk,
  input  logic                              rst_n,
  lprp_in_if.sink                           in_ch,
  lprp_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [lprp_pkg::CIDX_W-1:0]       cfg_index,
  input  logic [lprp_pkg::CFG_W-1:0]        cfg_wdata
);

  // Configuration registers.
  logic [lprp_pkg::BODY_W-1:0] max_body_len_r;
  logic [lprp_pkg::ARGC_W-1:0] max_arg_count_r;
  logic [lprp_pkg::BODY_W-1:0] body_lim;
  logic [lprp_pkg::ARGC_W-1:0] arg_lim;

  // Input register.
  logic                        s1_valid_r;
  logic [lprp_pkg::BYTE_W-1:0] s1_byte_r;

  // Parse state.
  lprp_pkg::parse_state_t      st_r;
  lprp_pkg::parse_state_t      st_nxt;

  // Output register.
  logic                        out_valid_r;
  lprp_pkg::parse_result_t     out_res_r;
  lprp_pkg::parse_result_t     res_nxt;

  logic                        advance;
  logic                        fire;
  logic                        in_fire;

  // A register value above the hard limit behaves as the hard limit.
  assign body_lim = (max_body_len_r > lprp_pkg::BODY_LIMIT) ? lprp_pkg::BODY_LIMIT
                                                             : max_body_len_r;
  assign arg_lim  = (max_arg_count_r > lprp_pkg::ARG_LIMIT) ? lprp_pkg::ARG_LIMIT
                                                             : max_arg_count_r;

  // The pipeline moves when the output register is empty or being drained.
  assign advance     = !out_valid_r || out_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_len_r  <= lprp_pkg::BODY_LIMIT;
      max_arg_count_r <= lprp_pkg::ARG_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        lprp_pkg::CFG_MAX_BODY_LEN:  max_body_len_r  <= cfg_wdata[lprp_pkg::BODY_W-1:0];
        lprp_pkg::CFG_MAX_ARG_COUNT: max_arg_count_r <= cfg_wdata[lprp_pkg::ARGC_W-1:0];
        default: ;
      endcase
    end
  end

  lprp_step u_step (
    .st_i       (st_r),
    .byte_i     (s1_byte_r),
    .body_lim_i (body_lim),
    .arg_lim_i  (arg_lim),
    .st_o       (st_nxt),
    .res_o      (res_nxt)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (fire) begin
        s1_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.rx_byte;
    end
    if (fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.byte_out     = out_res_r.byte_out;
  assign out_ch.byte_role    = out_res_r.byte_role;
  assign out_ch.arg_number   = out_res_r.arg_number;
  assign out_ch.arg_done     = out_res_r.arg_done;
  assign out_ch.request_done = out_res_r.request_done;
  assign out_ch.error_code   = out_res_r.error_code;

  // Once closed, the parser never reopens before reset.
  a_closed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.closed |=> st_r.closed)
    else $error("parser reopened after an error");

  // A byte that raises an error closes the parser.
  a_error_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res_nxt.error_code != lprp_pkg::ERR_NONE) |=> st_r.closed)
    else $error("error did not close the parser");

  // A request is never reported complete on an error byte.
  a_no_done_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.error_code != lprp_pkg::ERR_NONE) |-> !out_res_r.request_done)
    else $error("request completion flagged together with an error");

  // Dropped bytes carry no marks and no error.
  a_drop_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.byte_role == lprp_pkg::ROLE_DROP) |->
      (out_res_r.error_code == lprp_pkg::ERR_NONE && !out_res_r.arg_done &&
       !out_res_r.request_done && out_res_r.arg_number == '0))
    else $error("dropped byte carries marks");

  // Only argument length or data bytes can end an argument.
  a_arg_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.arg_done) |->
      (out_res_r.byte_role == lprp_pkg::ROLE_ALEN || out_res_r.byte_role == lprp_pkg::ROLE_DATA))
    else $error("argument end on a non-argument byte");

endmodule

// ===== tb/sv/lprp_tag_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lprp_tag_checker: prediction and checking of tagged request bytes
// Watches the byte channels and the limit writes of the parser, keeps its
// own copy of the parse state and compares every output beat with the
// oldest predicted tag.
// ----------------------------------------------------------------------------
module lprp_tag_checker
  import lprp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  lprp_in_if                in_ch,
  lprp_out_if               out_ch,
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output int                tags_pending,
  output int                mismatches
);

  logic [1:0]        phase;
  logic [1:0]        fill;
  logic [HDR_W-1:0]  word;
  logic [BODY_W-1:0] body_left;
  logic [ARGC_W-1:0] args_left;
  logic [ARGI_W-1:0] arg_idx;
  logic [BODY_W-1:0] data_left;
  logic              closed;
  logic [CFG_W-1:0]  body_cfg;
  logic [ARGC_W-1:0] args_cfg;
  parse_result_t     expected_tags[$];

  // The count or an argument has ended: move to the next header, close the
  // request, or report what is wrong with the rest of the body.
  function automatic logic [ERR_W-1:0] after_item(output logic done);
    done = 1'b0;
    if (args_left != '0) begin
      if (body_left < HDR_BYTES) return ERR_HDR_OVR;
      phase = PH_ALEN;
      return ERR_NONE;
    end
    if (body_left != '0) return ERR_TRAILING;
    done    = 1'b1;
    phase   = PH_LEN;
    arg_idx = '0;
    return ERR_NONE;
  endfunction

  function automatic logic [ERR_W-1:0] finish_arg(output logic adone, output logic rdone);
    adone = 1'b1;
    if (args_left != '0) args_left = args_left - 1'b1;
    arg_idx = arg_idx + 1'b1;
    return after_item(rdone);
  endfunction

  function automatic parse_result_t predict_tags(input logic [BYTE_W-1:0] b);
    parse_result_t     r;
    logic [BODY_W-1:0] blim;
    logic [ARGC_W-1:0] alim;
    logic [ARGI_W-1:0] idx_now;
    logic              full;
    logic              adone;
    logic              rdone;
    logic [ERR_W-1:0]  err;
    r           = '0;
    r.byte_out  = b;
    r.byte_role = ROLE_DROP;
    full        = 1'b0;
    adone       = 1'b0;
    rdone       = 1'b0;
    err         = ERR_NONE;
    if (!closed) begin
      blim    = (body_cfg < BODY_LIMIT) ? body_cfg : BODY_LIMIT;
      alim    = (args_cfg < ARG_LIMIT) ? args_cfg : ARG_LIMIT;
      idx_now = arg_idx;
      if (phase != PH_LEN && body_left != '0) body_left = body_left - 1'b1;
      // Header bytes shift in from the top, so a full word is little-endian.
      if (phase != PH_DATA) begin
        word = {b, word[HDR_W-1:BYTE_W]};
        fill = fill + 1'b1;
        full = (fill == '0);
      end
      case (phase)
        PH_LEN: begin
          r.byte_role = ROLE_LEN;
          if (full) begin
            if (word > blim) err = ERR_LEN_BIG;
            else if (word < MIN_BODY) err = ERR_LEN_SMALL;
            else begin
              body_left = word[BODY_W-1:0];
              phase     = PH_COUNT;
            end
          end
        end
        PH_COUNT: begin
          r.byte_role = ROLE_COUNT;
          if (full) begin
            if (word > alim) err = ERR_ARGS;
            else begin
              args_left = word[ARGC_W-1:0];
              arg_idx   = '0;
              err       = after_item(rdone);
            end
          end
        end
        PH_ALEN: begin
          r.byte_role  = ROLE_ALEN;
          r.arg_number = idx_now;
          if (full) begin
            if (word > body_left) err = ERR_DATA_OVR;
            else if (word == '0) err = finish_arg(adone, rdone);
            else begin
              data_left = word[BODY_W-1:0];
              phase     = PH_DATA;
            end
          end
        end
        default: begin
          r.byte_role  = ROLE_DATA;
          r.arg_number = idx_now;
          if (data_left != '0) data_left = data_left - 1'b1;
          if (data_left == '0) err = finish_arg(adone, rdone);
        end
      endcase
      if (err != ERR_NONE) begin
        closed = 1'b1;
        rdone  = 1'b0;
      end
    end
    r.arg_done     = adone;
    r.request_done = rdone;
    r.error_code   = err;
    return r;
  endfunction

  function automatic string tag_text(input parse_result_t t);
    return $sformatf("byte=%h role=%0d arg=%0d arg_done=%b req_done=%b err=%0d",
                     t.byte_out, t.byte_role, t.arg_number, t.arg_done,
                     t.request_done, t.error_code);
  endfunction

  function automatic void report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, what);
  endfunction

  always @(posedge clk) begin
    parse_result_t got;
    parse_result_t want;
    if (!rst_n) begin
      phase     = PH_LEN;
      fill      = '0;
      word      = '0;
      body_left = '0;
      args_left = '0;
      arg_idx   = '0;
      data_left = '0;
      closed    = 1'b0;
      body_cfg  = BODY_LIMIT;
      args_cfg  = ARG_LIMIT;
      expected_tags.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_BODY_LEN:  body_cfg = cfg_wdata;
          CFG_MAX_ARG_COUNT: args_cfg = cfg_wdata[ARGC_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        expected_tags.insert(expected_tags.size(), predict_tags(in_ch.rx_byte));
      if (out_ch.valid && out_ch.ready) begin
        got.byte_out     = out_ch.byte_out;
        got.byte_role    = out_ch.byte_role;
        got.arg_number   = out_ch.arg_number;
        got.arg_done     = out_ch.arg_done;
        got.request_done = out_ch.request_done;
        got.error_code   = out_ch.error_code;
        if (expected_tags.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: %s", tag_text(got)));
        end else begin
          want = expected_tags.pop_front();
          if (got !== want)
            report_mismatch($sformatf("tag mismatch: expected %s, got %s",
                                      tag_text(want), tag_text(got)));
        end
      end
    end
    tags_pending = expected_tags.size();
  end

endmodule

// ===== tb/sv/length_prefixed_request_parser_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// length_prefixed_request_parser_core_tb: top of the parser testbench
// Drives request byte streams into the parser with random gaps and output
// stalls, changes the two limits between segments, and ends the run with one
// malformed request that closes the parser. A checker beside the parser
// predicts every tagged byte; this module gives the verdict.
// ----------------------------------------------------------------------------
module length_prefixed_request_parser_core_tb;
  import lprp_pkg::*;

  localparam int SEGMENT_BYTES   = 160;  // bytes per limit setting
  localparam int RANDOM_SEGMENTS = 6;
  localparam int NOISE_BYTES     = 40;   // dropped bytes after the closing error
  localparam int LONG_HOLD       = 40;   // cycles of the long receiver hold-off
  localparam int DRAIN_CYCLES    = 8;    // margin after the prediction queue empties

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]  cfg_wdata;
  int                tags_pending;
  int                mismatches;

  lprp_in_if  byte_in ();
  lprp_out_if tag_out ();

  // Bytes of the request being built, and the limits the parser applies
  // right now (register values clamped to the hard limits). The stimulus
  // uses these only to shape well-formed requests; the checker keeps its own.
  logic [BYTE_W-1:0] request_bytes[$];
  int                body_lim;
  int                arg_lim;
  int                bytes_sent;
  int                beats_taken;
  bit                src_burst;
  bit                sink_burst;

  length_prefixed_request_parser_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (byte_in),
    .out_ch    (tag_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  lprp_tag_checker tag_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (byte_in),
    .out_ch       (tag_out),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .tags_pending (tags_pending),
    .mismatches   (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a handshake never completes. The slowest correct run
  // stays far below this.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // A 32-bit header field goes out least significant byte first.
  function automatic void push_word(input logic [HDR_W-1:0] w);
    for (int i = 0; i < 4; i++) request_bytes.insert(request_bytes.size(), w[8*i +: 8]);
  endfunction

  function automatic void push_data(input int n);
    repeat (n) request_bytes.insert(request_bytes.size(), BYTE_W'($urandom_range(0, 255)));
  endfunction

  // Builds one request that the current limits accept. Most requests are
  // short with a handful of small arguments; now and then one argument takes
  // all the spare room, so the body lands exactly on the length limit.
  function automatic void build_request();
    int budget;
    int nmax;
    int n;
    int total;
    int spare;
    int len;
    int lens[$];
    budget = body_lim - 4;
    nmax   = budget / 4;
    if (arg_lim < nmax) nmax = arg_lim;
    if ($urandom_range(0, 9) < 7) n = $urandom_range(0, (nmax < 4) ? nmax : 4);
    else n = $urandom_range(0, (nmax < 16) ? nmax : 16);
    total = 4;
    for (int i = 0; i < n; i++) begin
      // Room left for this argument's data once every remaining header fits.
      spare = budget - (total - 4) - 4 * (n - i);
      case ($urandom_range(0, 9))
        8:       len = $urandom_range(0, (spare < 200) ? spare : 200);
        9:       len = (spare <= 300) ? spare : $urandom_range(0, 300);
        default: len = $urandom_range(0, (spare < 12) ? spare : 12);
      endcase
      total += 4 + len;
      lens.insert(lens.size(), len);
    end
    push_word(HDR_W'(total));
    push_word(HDR_W'(n));
    foreach (lens[i]) begin
      push_word(HDR_W'(lens[i]));
      push_data(lens[i]);
    end
  endfunction

  // Builds a request that should fail with the given error. Whether it
  // really does depends on the limits in force; the checker decides.
  // ERR_NONE stands for plain garbage.
  function automatic void build_broken(input logic [ERR_W-1:0] kind);
    int len;
    int rest;
    len  = $urandom_range(0, 6);
    rest = $urandom_range(0, 3);
    case (kind)
      ERR_LEN_BIG:
        push_word($urandom_range(0, 1) ? HDR_W'(body_lim + 1) : ($urandom | 32'h8000_0000));
      ERR_LEN_SMALL:
        push_word(HDR_W'(rest));
      ERR_ARGS: begin
        push_word(HDR_W'(4));
        push_word($urandom_range(0, 1) ? HDR_W'(arg_lim + 1) : ($urandom | 32'h8000_0000));
      end
      ERR_HDR_OVR: begin
        // Either the count itself or the end of the first argument leaves
        // another header due with fewer than four body bytes.
        if ($urandom_range(0, 1)) begin
          push_word(HDR_W'(4 + rest));
          push_word(HDR_W'($urandom_range(1, 3)));
        end else begin
          push_word(HDR_W'(8 + len + rest));
          push_word(HDR_W'(2));
          push_word(HDR_W'(len));
          push_data(len);
        end
      end
      ERR_DATA_OVR: begin
        push_word(HDR_W'(8 + len));
        push_word(HDR_W'(1));
        push_word(HDR_W'(len + 1 + rest));
      end
      ERR_TRAILING: begin
        rest = $urandom_range(1, 3);
        if ($urandom_range(0, 1)) begin
          push_word(HDR_W'(4 + rest));
          push_word(HDR_W'(0));
        end else begin
          push_word(HDR_W'(8 + len + rest));
          push_word(HDR_W'(1));
          push_word(HDR_W'(len));
          push_data(len);
        end
        push_data(rest);
      end
      default: push_data(8);
    endcase
  endfunction

  // Offers one byte and returns at the falling edge after its beat. The gap
  // before it comes from the sender's idle draw, which switches now and then
  // into a burst mode with no gaps at all. Valid is raised only once per
  // step, so a back-to-back byte keeps valid high without a glitch.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      byte_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_in.valid   <= 1'b1;
    byte_in.rx_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_request();
    foreach (request_bytes[i]) send_byte(request_bytes[i]);
    request_bytes.delete();
  endtask

  // Writes both limits once the parser has nothing in flight. Every byte
  // yields exactly one beat, so an empty prediction queue means both
  // pipeline registers are empty; the extra cycles are only margin.
  task automatic set_limits(input int body, input int args);
    byte_in.valid <= 1'b0;
    wait (tags_pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_BODY_LEN;
    cfg_wdata <= CFG_W'(body);
    @(negedge clk);
    cfg_index <= CFG_MAX_ARG_COUNT;
    cfg_wdata <= CFG_W'(args);
    @(negedge clk);
    cfg_we   <= 1'b0;
    body_lim = (body < int'(BODY_LIMIT)) ? body : int'(BODY_LIMIT);
    arg_lim  = (args < int'(ARG_LIMIT)) ? args : int'(ARG_LIMIT);
  endtask

  // Receiver: before each beat it holds ready low for a drawn number of
  // cycles, with burst stretches of none. Twice or so in the run it holds
  // off for a long stretch while the sender keeps offering, so the output
  // register and the input register both fill and input ready drops.
  initial begin : receiver
    int gap;
    tag_out.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
      gap = sink_burst ? 0 : $urandom_range(0, 3);
      if (beats_taken % 800 == 300) gap = LONG_HOLD;
      if (gap > 0) begin
        tag_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      tag_out.ready <= 1'b1;
      do @(posedge clk); while (!tag_out.valid);
      beats_taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int               seg_start;
    logic [ERR_W-1:0] kind;
    byte_in.valid   = 1'b0;
    byte_in.rx_byte = '0;
    cfg_we          = 1'b0;
    cfg_index       = CFG_MAX_BODY_LEN;
    cfg_wdata       = '0;
    rst_n           = 1'b0;
    body_lim        = int'(BODY_LIMIT);
    arg_lim         = int'(ARG_LIMIT);
    bytes_sent      = 0;
    beats_taken     = 0;
    src_burst       = 1'b0;
    sink_burst      = 1'b0;
    // Hold synchronous reset, then release it.
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset limits: the smallest legal request
    // (body of four bytes, no arguments), then one with a zero-length
    // argument followed by an argument carrying the byte extremes.
    push_word(HDR_W'(4));
    push_word(HDR_W'(0));
    push_word(HDR_W'(14));
    push_word(HDR_W'(2));
    push_word(HDR_W'(0));
    push_word(HDR_W'(2));
    request_bytes.insert(request_bytes.size(), 8'h00);
    request_bytes.insert(request_bytes.size(), 8'hFF);
    send_request();

    // Random well-formed requests under a series of limits: reset values,
    // the tightest setting (only empty four-byte bodies pass), registers
    // above the hard limits so the clamp acts, and random settings.
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      case (seg)
        1:       set_limits(4, 0);
        2:       set_limits(8191, 2047);
        3:       set_limits($urandom_range(4, 300), $urandom_range(0, 16));
        4:       set_limits($urandom_range(8, 64), 1);
        5:       set_limits($urandom_range(4, 8191), $urandom_range(0, 2047));
        default: ;
      endcase
      seg_start = bytes_sent;
      while (bytes_sent - seg_start < SEGMENT_BYTES) begin
        build_request();
        send_request();
      end
    end

    // Any error closes the parser for the rest of the run, and reset comes
    // only once, so the error case goes last: a random limit setting (now
    // and then a body limit under four), a few good requests, one broken
    // request of a random kind, then bytes that must all come out dropped.
    set_limits(($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 8191),
               ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 2047));
    if (body_lim >= 4) begin
      repeat ($urandom_range(1, 3)) begin
        build_request();
        send_request();
      end
    end
    kind = ERR_W'($urandom_range(0, 6));
    build_broken(kind);
    push_data(NOISE_BYTES);
    send_request();
    byte_in.valid <= 1'b0;

    // Drain: wait for every predicted beat, then a few latencies more so a
    // stray extra beat would still be caught.
    wait (tags_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/lprp_pkg.sv
hdl/lprp_in_if.sv
hdl/lprp_out_if.sv
hdl/lprp_step.sv
hdl/length_prefixed_request_parser_core.sv
tb/sv/lprp_tag_checker.sv
tb/sv/length_prefixed_request_parser_core_tb.sv
